[rtl/core/hsec_pkg.sv]
// ----------------------------------------------------------------------------
// hsec_pkg: shared types and constants for the Hamming SEC encoder/corrector
// Word widths, data bit limits and the result bundle passed between modules.
// ----------------------------------------------------------------------------
package hsec_pkg;

    localparam int C_WORD_W        = 63;   // widest codeword
    localparam int C_POS_W         = 6;    // syndrome / position width
    localparam int C_CFG_W         = 6;    // data_bits register width
    localparam int C_MAX_DATA_BITS = 57;
    localparam int C_RESET_DATA    = 4;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;

    typedef struct packed {
        logic [C_WORD_W-1:0] word;
        logic                found;
        logic [C_POS_W-1:0]  pos;
        logic                unc;
    } t_result;

    // code length n = m + r for a raw data_bits value (saturated to 1..max)
    function automatic logic [C_POS_W-1:0] f_code_len(input logic [C_CFG_W-1:0] raw);
        logic [C_CFG_W-1:0] m;
        logic [3:0]         r;
        logic               done;
        m    = raw;
        r    = 4'd0;
        done = 1'b0;
        if (m == '0) begin
            m = C_CFG_W'(1);
        end
        if (m > C_CFG_W'(C_MAX_DATA_BITS)) begin
            m = C_CFG_W'(C_MAX_DATA_BITS);
        end
        for (int k = 0; k <= 6; k++) begin
            if (!done) begin
                if ((8'd1 << k) >= (8'(m) + 8'(k) + 8'd1)) begin
                    r    = 4'(k);
                    done = 1'b1;
                end
            end
        end
        return C_POS_W'(7'(m) + 7'(r));
    endfunction

endpackage

[rtl/core/hsec_core.sv]
// ----------------------------------------------------------------------------
// hsec_core: Hamming SEC datapath
// Data bit placement, parity generation, syndrome and single bit correction.
// ----------------------------------------------------------------------------
module hsec_core (
    input  logic                          i_action,
    input  logic [hsec_pkg::C_WORD_W-1:0] i_word,
    input  logic [hsec_pkg::C_POS_W-1:0]  i_code_len,
    output hsec_pkg::t_result             o_result
);
    import hsec_pkg::*;

    // positions p whose bit i is set, bit p-1 of the mask
    function automatic logic [C_WORD_W-1:0] f_pos_mask(input int i);
        logic [C_WORD_W-1:0] v;
        v = '0;
        for (int p = 1; p <= C_WORD_W; p++) begin
            v[p-1] = p[i];
        end
        return v;
    endfunction

    function automatic logic [C_POS_W-1:0] f_syndrome(input logic [C_WORD_W-1:0] w);
        logic [C_POS_W-1:0] s;
        for (int i = 0; i < C_POS_W; i++) begin
            s[i] = ^(w & f_pos_mask(i));
        end
        return s;
    endfunction

    logic [C_WORD_W-1:0] len_mask;
    logic [C_WORD_W-1:0] spread;
    logic [C_WORD_W-1:0] base;
    logic [C_POS_W-1:0]  syn;
    logic [C_WORD_W-1:0] enc_word;

    always_comb begin
        for (int p = 1; p <= C_WORD_W; p++) begin
            len_mask[p-1] = (C_POS_W'(p) <= i_code_len);
        end
    end

    // data bit k lands on the k-th non power of two position
    always_comb begin
        int k;
        k      = 0;
        spread = '0;
        for (int p = 1; p <= C_WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                spread[p-1] = i_word[k];
                k++;
            end
        end
    end

    assign base = ((i_action == ACT_CHECK) ? i_word : spread) & len_mask;
    assign syn  = f_syndrome(base);

    always_comb begin
        enc_word = base;
        for (int i = 0; i < C_POS_W; i++) begin
            enc_word[(1 << i) - 1] = syn[i];
        end
        enc_word = enc_word & len_mask;
    end

    always_comb begin
        o_result = '0;
        if (i_action == ACT_ENCODE) begin
            o_result.word = enc_word;
        end else begin
            o_result.word = base;
            if (syn != '0) begin
                o_result.found = 1'b1;
                o_result.pos   = syn;
                if (syn <= i_code_len) begin
                    o_result.word = base ^ (C_WORD_W'(1) << (syn - C_POS_W'(1)));
                end else begin
                    o_result.unc = 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/hamming_sec_encode_correct.sv]
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct: variable length Hamming SEC encoder / corrector
// Encodes data bits into a codeword or checks and corrects a received word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  input   | in        | i_valid / o_ready  | i_action, i_word_in
//  result  | out       | o_valid / i_ready  | o_word_out, o_error_found,
//          |           |                    | o_error_position, o_uncorrectable
//  config  | in        | i_cfg_we           | i_cfg_data (data_bits)
//
//  One transaction per cycle sustained while the result is not stalled; input
//  acceptance loads the input register, then the result register raises valid.
//  The XOR trees of hsec_core sit between the two register stages.
//  Synchronous active low reset empties both stages and sets data_bits to 4.
//  A stalled result holds; the input stage still accepts while the result
//  register can drain, so ready only drops when both stages are full and the
//  result is not being taken.
// ----------------------------------------------------------------------------
module hamming_sec_encode_correct (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hsec_pkg::C_CFG_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [hsec_pkg::C_WORD_W-1:0] i_word_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hsec_pkg::C_WORD_W-1:0] o_word_out,
    output logic                          o_error_found,
    output logic [hsec_pkg::C_POS_W-1:0]  o_error_position,
    output logic                          o_uncorrectable
);
    import hsec_pkg::*;

    // code length derived once at config time, kept as a register
    logic [C_POS_W-1:0]  r_code_len;

    logic                r_in_valid;
    logic                r_in_action;
    logic [C_WORD_W-1:0] r_in_word;

    logic                r_out_valid;
    t_result             r_out;

    logic                n_in_valid;
    logic                n_out_valid;
    logic                out_ready;
    logic                in_load;
    logic                out_load;
    t_result             core_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_len <= f_code_len(C_CFG_W'(C_RESET_DATA));
        end else if (i_cfg_we) begin
            r_code_len <= f_code_len(i_cfg_data);
        end
    end

    // result stage frees when empty or being taken
    assign out_ready = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || out_ready;
    assign in_load   = i_valid && o_ready;
    assign out_load  = r_in_valid && out_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_load) begin
            n_in_valid = 1'b1;
        end else if (out_load) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_action <= i_action;
            r_in_word   <= i_word_in;
        end
        if (out_load) begin
            r_out <= core_res;
        end
    end

    hsec_core u_core (
        .i_action   (r_in_action),
        .i_word     (r_in_word),
        .i_code_len (r_code_len),
        .o_result   (core_res)
    );

    assign o_valid          = r_out_valid;
    assign o_word_out       = r_out.word;
    assign o_error_found    = r_out.found;
    assign o_error_position = r_out.pos;
    assign o_uncorrectable  = r_out.unc;

`ifndef SYNTHESIS
    a_unc_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_uncorrectable) |-> o_error_found)
        else $error("uncorrectable without error_found");

    a_pos_matches_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_found == (o_error_position != '0)))
        else $error("error_position disagrees with error_found");

    a_no_bits_past_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_word_out >> r_code_len) == '0))
        else $error("codeword bits set beyond code length");

    a_code_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_code_len >= C_POS_W'(3)) && (r_code_len <= C_POS_W'(C_WORD_W)))
        else $error("code length out of range");

    a_in_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> (r_in_valid && $stable(r_in_word)))
        else $error("input stage lost a stalled transaction");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hamming_sec_encode_correct
// Drives encode and check transactions over a range of data_bits settings,
// predicts each codeword, syndrome and flag set in the bench, and compares
// every result transaction field by field, in order, under random stalls.
// ----------------------------------------------------------------------------
module testbench;

    import hsec_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;  // well above the slowest legal run
    localparam int PIPE_LATENCY = 2;       // input stage plus result stage
    localparam int IDLE_PCT     = 38;      // idle cycles per hundred, each side
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 14;

    // DUT inputs start known; reset is held low from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [C_CFG_W-1:0]   i_cfg_data = '0;
    logic                 i_valid    = 1'b0;
    logic                 i_action   = ACT_ENCODE;
    logic [C_WORD_W-1:0]  i_word_in  = '0;
    logic                 i_ready    = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [C_WORD_W-1:0]  o_word_out;
    logic                 o_error_found;
    logic [C_POS_W-1:0]   o_error_position;
    logic                 o_uncorrectable;

    // bench copy of the data_bits register, updated with every write
    logic [C_CFG_W-1:0]   data_bits_shadow = C_CFG_W'(C_RESET_DATA);
    t_result              code_results_due[$];
    bit                   steady_flow    = 1'b0;  // both sides stop idling
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    hamming_sec_encode_correct DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_word_in        (i_word_in),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_word_out       (o_word_out),
        .o_error_found    (o_error_found),
        .o_error_position (o_error_position),
        .o_uncorrectable  (o_uncorrectable)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // n = m + r, with m clamped to 1..max and r the smallest count with
    // 2^r >= m + r + 1
    function automatic int code_length(input logic [C_CFG_W-1:0] raw);
        int m;
        int r;
        m = int'(raw);
        r = 0;
        if (m < 1) m = 1;
        if (m > C_MAX_DATA_BITS) m = C_MAX_DATA_BITS;
        while ((1 << r) < m + r + 1) r++;
        return m + r;
    endfunction

    function automatic logic [C_WORD_W-1:0] word_mask(input int n);
        if (n >= C_WORD_W) return '1;
        return (C_WORD_W'(1) << n) - C_WORD_W'(1);
    endfunction

    // XOR of the one-based positions of all set bits in positions 1..n
    function automatic int syndrome_of(input logic [C_WORD_W-1:0] cw, input int n);
        int s;
        s = 0;
        for (int p = 1; p <= n; p++) begin
            if (cw[p-1]) s ^= p;
        end
        return s;
    endfunction

    function automatic t_result hamming_code_of(input logic [C_CFG_W-1:0] raw,
                                                input logic act,
                                                input logic [C_WORD_W-1:0] w);
        t_result             res;
        logic [C_WORD_W-1:0] cw;
        int                  n;
        int                  k;
        int                  s;
        n   = code_length(raw);
        res = '0;
        cw  = '0;
        k   = 0;
        if (act == ACT_ENCODE) begin
            // data bits fill the non power-of-two positions in order
            for (int p = 1; p <= n; p++) begin
                if ((p & (p - 1)) != 0) begin
                    cw[p-1] = w[k];
                    k++;
                end
            end
            // with parity slots still zero the syndrome is the parity vector
            s = syndrome_of(cw, n);
            for (int i = 0; i < C_POS_W; i++) begin
                if (s[i]) cw[(1 << i) - 1] = 1'b1;
            end
        end else begin
            cw = w & word_mask(n);
            s  = syndrome_of(cw, n);
            if (s != 0) begin
                res.found = 1'b1;
                res.pos   = C_POS_W'(s);
                if (s <= n) cw[s-1] = ~cw[s-1];
                else res.unc = 1'b1;
            end
        end
        res.word = cw;
        return res;
    endfunction

    function automatic logic [C_WORD_W-1:0] random_word();
        return C_WORD_W'({$urandom(), $urandom()});
    endfunction

    function automatic logic [C_WORD_W-1:0] codeword_of(input logic [C_WORD_W-1:0] data);
        t_result enc;
        enc = hamming_code_of(data_bits_shadow, ACT_ENCODE, data);
        return enc.word;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one transaction per call, valid held until accepted
    // ------------------------------------------------------------------------
    task automatic send_word(input logic act, input logic [C_WORD_W-1:0] w);
        // random idle cycles before the next transaction
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_word_in <= w;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        code_results_due.push_back(hamming_code_of(data_bits_shadow, act, w));
        @(negedge i_clk);
    endtask

    // quiesce the input, let every outstanding result come back, then
    // allow the pipeline latency to pass
    task automatic drain_results();
        i_valid <= 1'b0;
        while (code_results_due.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    // register writes only with the block idle
    task automatic set_data_bits(input logic [C_CFG_W-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we         <= 1'b0;
        data_bits_shadow  = value;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random backpressure and in-order result checking
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : result_check
        t_result due;
        if (i_rst_n && o_valid && i_ready) begin
            if (code_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result with none pending: word=%h found=%b pos=%0d unc=%b",
                             o_word_out, o_error_found, o_error_position, o_uncorrectable);
            end else begin
                due = code_results_due.pop_front();
                if (o_word_out !== due.word || o_error_found !== due.found ||
                    o_error_position !== due.pos || o_uncorrectable !== due.unc) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: cycle %0d expected word=%h found=%b pos=%0d unc=%b",
                                 cycle_count, due.word, due.found, due.pos, due.unc);
                        $display("       actual   word=%h found=%b pos=%0d unc=%b",
                                 o_word_out, o_error_found, o_error_position,
                                 o_uncorrectable);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // data_bits comes out of reset as 4: the (7,4) code, no write needed
    task automatic test_reset_setting();
        send_word(ACT_ENCODE, '1);
        send_word(ACT_ENCODE, C_WORD_W'('h5));
        send_word(ACT_CHECK, codeword_of(C_WORD_W'('hB)) ^ C_WORD_W'('h4));
    endtask

    // one data bit, n = 3; surplus input bits must be dropped
    task automatic test_smallest_code();
        set_data_bits(C_CFG_W'(1));
        send_word(ACT_ENCODE, '0);
        send_word(ACT_ENCODE, '1);
        send_word(ACT_CHECK, '1);
        send_word(ACT_CHECK, C_WORD_W'('h7FF0_0000_0000_0004));
    endtask

    // zero saturates up to one, values past the maximum saturate down
    task automatic test_saturation();
        set_data_bits(C_CFG_W'(0));
        send_word(ACT_ENCODE, '1);
        set_data_bits(C_CFG_W'(63));
        send_word(ACT_ENCODE, '1);
        send_word(ACT_CHECK, '1);
        set_data_bits(C_CFG_W'(58));
        send_word(ACT_CHECK, C_WORD_W'(1) << (C_WORD_W - 1));
    endtask

    // 57 data bits fill all 63 positions; errors at both ends of the word
    task automatic test_widest_code();
        set_data_bits(C_CFG_W'(C_MAX_DATA_BITS));
        send_word(ACT_ENCODE, '1);
        send_word(ACT_ENCODE, '0);
        send_word(ACT_CHECK, codeword_of(random_word()) ^ (C_WORD_W'(1) << (C_WORD_W - 1)));
        send_word(ACT_CHECK, codeword_of(random_word()) ^ C_WORD_W'(1));
    endtask

    // syndrome points past the code length: flagged, word passed through
    task automatic test_uncorrectable();
        set_data_bits(C_CFG_W'(2));                       // n = 5
        send_word(ACT_CHECK, C_WORD_W'('b01010));         // positions 2,4 -> 6
        set_data_bits(C_CFG_W'(5));                       // n = 9
        send_word(ACT_CHECK, C_WORD_W'('h82));            // positions 2,8 -> 10
        set_data_bits(C_CFG_W'(27));                      // n = 33
        send_word(ACT_CHECK, C_WORD_W'('h8000_0002));     // positions 2,32 -> 34
    endtask

    // mostly codewords with zero, one or two bit errors, plus raw noise
    task automatic send_random_item();
        logic [C_WORD_W-1:0] cw;
        logic [C_WORD_W-1:0] mask;
        int                  n;
        int                  pick;
        int                  a;
        int                  b;
        n    = code_length(data_bits_shadow);
        mask = word_mask(n);
        pick = $urandom_range(99);
        cw   = codeword_of(random_word());
        if ($urandom_range(3) == 0) cw |= random_word() & ~mask;
        a = $urandom_range(n - 1);
        b = (a + $urandom_range(1, n - 1)) % n;  // distinct from a
        if (pick < 30)
            send_word(ACT_ENCODE, random_word());
        else if (pick < 50)
            send_word(ACT_CHECK, cw);
        else if (pick < 80)
            send_word(ACT_CHECK, cw ^ (C_WORD_W'(1) << a));
        else if (pick < 92)
            send_word(ACT_CHECK, cw ^ (C_WORD_W'(1) << a) ^ (C_WORD_W'(1) << b));
        else
            send_word(logic'($urandom_range(1)), random_word());
    endtask

    // phases at the extremes first, then random settings; one phase runs
    // with no idling on either side
    task automatic test_random_traffic();
        logic [C_CFG_W-1:0] setting;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    setting = C_CFG_W'(C_MAX_DATA_BITS);
                end
                1: begin
                    setting = C_CFG_W'(1);
                end
                2: begin
                    setting = C_CFG_W'(0);
                end
                3: begin
                    setting = '1;
                end
                default: begin
                    setting = C_CFG_W'($urandom_range(0, (1 << C_CFG_W) - 1));
                end
            endcase
            set_data_bits(setting);
            steady_flow = (phase == 4);
            for (int item = 0; item < PHASE_ITEMS; item++) send_random_item();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_setting();
        test_smallest_code();
        test_saturation();
        test_widest_code();
        test_uncorrectable();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
